// ===== hw/rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon crossing-number core.
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int COORD_BITS   = 16;
   localparam int MAX_VERTICES = 16;
   localparam int MIN_VERTICES = 3;
   localparam int IDX_BITS     = $clog2(MAX_VERTICES);
   localparam int COUNT_BITS   = 5;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * DIFF_BITS;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_TEST  = 1'b1;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(MIN_VERTICES);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   // Advance strobes for the lane stages.
   typedef struct packed {
      logic s2;
      logic s3;
   } adv_type;

endpackage

// ===== hw/rtl/pip_edge_lane.sv =====
// ----------------------------------------------------------------------------
// pip_edge_lane
// One polygon edge: straddle check and exact crossing test by
// cross-multiplication, over two register stages.
// ----------------------------------------------------------------------------
module pip_edge_lane (
   input  logic                clock,
   input  pip_pkg::adv_type    adv,
   input  logic                active,
   input  pip_pkg::point_type  vtx_a,
   input  pip_pkg::point_type  vtx_b,
   input  pip_pkg::point_type  query,
   output logic                hit
);

   pip_pkg::diff_type dx_in, dy_in, dq_in, dp_in;
   logic              straddle_in, up_in;

   pip_pkg::diff_type dx_ff, dy_ff, dq_ff, dp_ff;
   logic              straddle_ff, up_ff;

   pip_pkg::prod_type lhs_ff, rhs_ff;
   logic              straddle3_ff, up3_ff;

   always_comb begin
      dx_in = pip_pkg::diff_type'(vtx_b.x) - pip_pkg::diff_type'(vtx_a.x);
      dy_in = pip_pkg::diff_type'(vtx_b.y) - pip_pkg::diff_type'(vtx_a.y);
      dq_in = pip_pkg::diff_type'(query.y) - pip_pkg::diff_type'(vtx_a.y);
      dp_in = pip_pkg::diff_type'(query.x) - pip_pkg::diff_type'(vtx_a.x);
      straddle_in = active &&
                    (((vtx_a.y <= query.y) && (vtx_b.y > query.y)) ||
                     ((vtx_b.y <= query.y) && (vtx_a.y > query.y)));
      up_in = vtx_b.y > vtx_a.y;
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         dx_ff       <= dx_in;
         dy_ff       <= dy_in;
         dq_ff       <= dq_in;
         dp_ff       <= dp_in;
         straddle_ff <= straddle_in;
         up_ff       <= up_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         lhs_ff       <= pip_pkg::prod_type'(dx_ff) * pip_pkg::prod_type'(dq_ff);
         rhs_ff       <= pip_pkg::prod_type'(dp_ff) * pip_pkg::prod_type'(dy_ff);
         straddle3_ff <= straddle_ff;
         up3_ff       <= up_ff;
      end
   end

   // For a falling edge both y differences are negative, which flips the
   // sense of the comparison.
   assign hit = straddle3_ff && (up3_ff ? (lhs_ff < rhs_ff) : (lhs_ff > rhs_ff));

endmodule

// ===== hw/rtl/point_in_polygon_test_core.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test_core
// Crossing-number point-in-polygon test against a stored vertex table.
// ----------------------------------------------------------------------------
// A test word moves through the input, difference, product and parity registers.
// Throughput: one word per cycle; all edges are evaluated in parallel lanes
// of a four-stage pipeline, so the rate is set by nothing but back-pressure.
// Vertex writes give no result and update the table in pipeline order.
// Reset clears the valid bits and sets the vertex count to three; the vertex
// table is not cleared.
module point_in_polygon_test_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [pip_pkg::IDX_BITS-1:0]        req_vertex_index,
   input  logic signed [pip_pkg::COORD_BITS-1:0] req_coord_x,
   input  logic signed [pip_pkg::COORD_BITS-1:0] req_coord_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_inside_res,
   input  logic                                csr_wr_en,
   input  logic [pip_pkg::COUNT_BITS-1:0]      csr_wr_data
);

   logic [pip_pkg::COUNT_BITS-1:0] count_ff, count_in, count_eff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic en1, en2, en3, en4;

   logic                          mode1_ff;
   logic [pip_pkg::IDX_BITS-1:0]  idx1_ff;
   pip_pkg::point_type            pt1_ff;

   pip_pkg::point_type vtx_ff [pip_pkg::MAX_VERTICES];

   pip_pkg::adv_type                  adv;
   logic [pip_pkg::MAX_VERTICES-1:0]  hits;
   logic                              inside_ff;

   // Each stage moves on when its successor is empty or moving.
   always_comb begin
      en4 = !v4_ff || !rsp_stall;
      en3 = !v3_ff || en4;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;
      v1_in = en1 ? req_valid : v1_ff;
      v2_in = en2 ? (v1_ff && (mode1_ff == pip_pkg::MODE_TEST)) : v2_ff;
      v3_in = en3 ? v2_ff : v3_ff;
      v4_in = en4 ? v3_ff : v4_ff;
      adv.s2 = en2;
      adv.s3 = en3;
   end

   assign req_stall = !en1;

   always_comb begin
      count_in = csr_wr_en ? csr_wr_data : count_ff;
      if (count_ff < pip_pkg::COUNT_BITS'(pip_pkg::MIN_VERTICES)) begin
         count_eff = pip_pkg::COUNT_BITS'(pip_pkg::MIN_VERTICES);
      end else if (count_ff > pip_pkg::COUNT_BITS'(pip_pkg::MAX_VERTICES)) begin
         count_eff = pip_pkg::COUNT_BITS'(pip_pkg::MAX_VERTICES);
      end else begin
         count_eff = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= pip_pkg::COUNT_RESET;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         v4_ff    <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         mode1_ff <= req_mode;
         idx1_ff  <= req_vertex_index;
         pt1_ff.x <= req_coord_x;
         pt1_ff.y <= req_coord_y;
      end
   end

   // A vertex word updates the table as it leaves stage one, so every test
   // word sees exactly the writes that were accepted before it.
   always_ff @(posedge clock) begin
      if (en2 && v1_ff && (mode1_ff == pip_pkg::MODE_WRITE)) begin
         vtx_ff[idx1_ff] <= pt1_ff;
      end
   end

   for (genvar i = 0; i < pip_pkg::MAX_VERTICES; i++) begin : g_lane
      localparam int NEXT = (i + 1) % pip_pkg::MAX_VERTICES;
      logic               active;
      pip_pkg::point_type vtx_b;

      always_comb begin
         active = pip_pkg::COUNT_BITS'(i) < count_eff;
         vtx_b  = (pip_pkg::COUNT_BITS'(i + 1) == count_eff) ? vtx_ff[0] : vtx_ff[NEXT];
      end

      pip_edge_lane u_lane (
         .clock  (clock),
         .adv    (adv),
         .active (active),
         .vtx_a  (vtx_ff[i]),
         .vtx_b  (vtx_b),
         .query  (pt1_ff),
         .hit    (hits[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         inside_ff <= ^hits;
      end
   end

   assign rsp_valid      = v4_ff;
   assign rsp_inside_res = inside_ff;

endmodule

// ===== tb/tb_point_in_polygon_test_core.sv =====
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test_core
// Self-checking bench for the crossing-number point-in-polygon core. A short
// table loads polygons with extreme coordinates and probes the corner cases.
// Random polygons and query points then run under several patterns of sender
// gaps and receiver stalls. Typed test rows give their own answer, the others
// come from a local copy of the vertex table; all are checked in order of arrival.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_test_core;

   localparam int SETTLE_CYCLES   = 8;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PHASES   = 10;
   localparam int WORDS_PER_PHASE = 40;
   localparam pip_pkg::coord_type COORD_MIN = 16'sh8000;
   localparam pip_pkg::coord_type COORD_MAX = 16'sh7FFF;

   typedef enum logic [1:0] {ROW_WRITE, ROW_TEST, ROW_COUNT} row_kind_type;
   typedef enum logic [1:0] {SHAPE_WIDE, SHAPE_TIGHT, SHAPE_CORNER} shape_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [pip_pkg::IDX_BITS-1:0]   index;
      pip_pkg::coord_type             x;
      pip_pkg::coord_type             y;
      logic [pip_pkg::COUNT_BITS-1:0] count;
      logic                           typed;
      logic                           answer;
   } stim_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_mode = pip_pkg::MODE_WRITE;
   logic [pip_pkg::IDX_BITS-1:0]   req_vertex_index = '0;
   pip_pkg::coord_type             req_coord_x = '0;
   pip_pkg::coord_type             req_coord_y = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_inside_res;
   logic                           csr_wr_en = 1'b0;
   logic [pip_pkg::COUNT_BITS-1:0] csr_wr_data = '0;

   // Local copy of the vertex table and the vertex count.
   pip_pkg::coord_type             poly_x [pip_pkg::MAX_VERTICES];
   pip_pkg::coord_type             poly_y [pip_pkg::MAX_VERTICES];
   logic [pip_pkg::COUNT_BITS-1:0] poly_count = pip_pkg::COUNT_RESET;

   logic         inside_queue [$];
   stim_row_type directed_rows [$];
   int           errors = 0;
   int           gap_pct = 0;
   int           stall_pct = 0;
   int           words_sent = 0;
   int           cycle_count = 0;

   point_in_polygon_test_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inside_res   (rsp_inside_res),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int active_corners();
      if (poly_count < pip_pkg::MIN_VERTICES) return pip_pkg::MIN_VERTICES;
      if (poly_count > pip_pkg::MAX_VERTICES) return pip_pkg::MAX_VERTICES;
      return poly_count;
   endfunction

   // Ray casting toward -x: each edge that straddles the query y under the
   // half-open rule and crosses strictly left of the point flips the parity.
   // The crossing test is cross-multiplied so that no division is needed.
   function automatic logic crossing_parity(pip_pkg::coord_type px,
                                            pip_pkg::coord_type py);
      int     corners;
      int     nxt;
      longint qx, qy, x0, y0, x1, y1, rise, span;
      logic   parity;
      corners = active_corners();
      qx = px;
      qy = py;
      parity = 1'b0;
      for (int i = 0; i < corners; i++) begin
         nxt = (i + 1 == corners) ? 0 : i + 1;
         x0 = poly_x[i];
         y0 = poly_y[i];
         x1 = poly_x[nxt];
         y1 = poly_y[nxt];
         if ((y0 <= qy && y1 > qy) || (y1 <= qy && y0 > qy)) begin
            rise = (qy > y0) ? qy - y0 : y0 - qy;
            span = (y1 > y0) ? y1 - y0 : y0 - y1;
            if ((x1 - x0) * rise < (qx - x0) * span) parity = ~parity;
         end
      end
      return parity;
   endfunction

   function automatic pip_pkg::coord_type pick_coord(shape_type shape);
      int v;
      case (shape)
         SHAPE_TIGHT: begin
            v = $urandom_range(18);
            return pip_pkg::coord_type'(v - 9);
         end
         SHAPE_CORNER: begin
            case ($urandom_range(4))
               0: return COORD_MIN;
               1: return -16'sd1;
               2: return 16'sd0;
               3: return 16'sd1;
               default: return COORD_MAX;
            endcase
         end
         default: return pip_pkg::coord_type'($urandom_range(16'hFFFF));
      endcase
   endfunction

   // Presents one word, holds it until accepted, then updates the local
   // table or queues the expected answer. Called just after a rising edge.
   task automatic send_word(logic mode, logic [pip_pkg::IDX_BITS-1:0] index,
                            pip_pkg::coord_type x, pip_pkg::coord_type y,
                            logic typed, logic answer);
      int   gap;
      logic predicted;
      gap = 0;
      while ($urandom_range(99) < gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_vertex_index <= index;
      req_coord_x      <= x;
      req_coord_y      <= y;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (mode == pip_pkg::MODE_WRITE) begin
         poly_x[index] = x;
         poly_y[index] = y;
      end else begin
         predicted = typed ? answer : crossing_parity(x, y);
         inside_queue = {inside_queue, predicted};
      end
   endtask

   // Waits for a rising edge before it first checks the queue, so that valid is never dropped and
   // raised again within one time step.
   task automatic drain_results(int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (inside_queue.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_count(logic [pip_pkg::COUNT_BITS-1:0] value);
      drain_results(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      poly_count = value;
   endtask

   task automatic send_polygon(int corners, shape_type shape);
      int rot;
      rot = $urandom_range(corners - 1);
      for (int k = 0; k < corners; k++)
         send_word(pip_pkg::MODE_WRITE, pip_pkg::IDX_BITS'((k + rot) % corners),
                   pick_coord(shape), pick_coord(shape), 1'b0, 1'b0);
   endtask

   // Query points either fall in the same coordinate range as the polygon,
   // sit exactly on a vertex, or share a vertex y to exercise the half-open
   // straddle rule.
   task automatic send_queries(int corners, shape_type shape, int count);
      int                 slot;
      pip_pkg::coord_type qx;
      pip_pkg::coord_type qy;
      for (int k = 0; k < count; k++) begin
         slot = $urandom_range(corners - 1);
         qx = pick_coord(shape);
         qy = pick_coord(shape);
         case ($urandom_range(3))
            0: begin
               qx = poly_x[slot];
               qy = poly_y[slot];
            end
            1: qy = poly_y[slot];
            default: ;
         endcase
         send_word(pip_pkg::MODE_TEST, pip_pkg::IDX_BITS'($urandom), qx, qy,
                   1'b0, 1'b0);
      end
   endtask

   always @(posedge clock) begin : result_check
      logic want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (inside_queue.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual inside_res=%0b",
                        $time, rsp_inside_res);
               errors++;
            end else begin
               want = inside_queue.pop_front();
               if (rsp_inside_res !== want) begin
                  $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                           $time, want, rsp_inside_res);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin : stimulus
      int           next_count;
      int           start;
      bit           paused;
      shape_type    shape;
      stim_row_type row;

      // The first triangle spans the whole coordinate range; two more vertex
      // writes and a count of four turn it into the full square, and a count
      // of zero folds back to a right triangle whose diagonal passes exactly
      // through the origin.
      directed_rows = '{
         '{ROW_WRITE, 4'd0,  COORD_MIN,      COORD_MIN,     5'd0, 1'b0, 1'b0},
         '{ROW_WRITE, 4'd1,  COORD_MAX,      COORD_MIN,     5'd0, 1'b0, 1'b0},
         '{ROW_WRITE, 4'd2,  16'sd0,         COORD_MAX,     5'd0, 1'b0, 1'b0},
         '{ROW_TEST,  4'd15, 16'sd0,         16'sd0,        5'd0, 1'b1, 1'b1},
         '{ROW_TEST,  4'd0,  COORD_MIN,      16'sd0,        5'd0, 1'b1, 1'b0},
         '{ROW_TEST,  4'd5,  COORD_MAX,      16'sd0,        5'd0, 1'b1, 1'b0},
         '{ROW_TEST,  4'd10, 16'sd0,         COORD_MAX,     5'd0, 1'b1, 1'b0},
         '{ROW_TEST,  4'd0,  16'sd0,         COORD_MIN,     5'd0, 1'b0, 1'b0},
         '{ROW_TEST,  4'd0,  COORD_MIN,      COORD_MIN,     5'd0, 1'b0, 1'b0},
         '{ROW_TEST,  4'd0,  COORD_MAX,      COORD_MAX,     5'd0, 1'b0, 1'b0},
         '{ROW_WRITE, 4'd2,  COORD_MAX,      COORD_MAX,     5'd0, 1'b0, 1'b0},
         '{ROW_WRITE, 4'd3,  COORD_MIN,      COORD_MAX,     5'd0, 1'b0, 1'b0},
         '{ROW_COUNT, 4'd0,  16'sd0,         16'sd0,        5'd4, 1'b0, 1'b0},
         '{ROW_TEST,  4'd0,  16'sd0,         16'sd0,        5'd0, 1'b1, 1'b1},
         '{ROW_TEST,  4'd0,  -16'sd1,        -16'sd1,       5'd0, 1'b0, 1'b0},
         '{ROW_TEST,  4'd0,  COORD_MAX,      16'sd0,        5'd0, 1'b0, 1'b0},
         '{ROW_TEST,  4'd0,  16'sd0,         COORD_MIN,     5'd0, 1'b0, 1'b0},
         '{ROW_COUNT, 4'd0,  16'sd0,         16'sd0,        5'd0, 1'b0, 1'b0},
         '{ROW_TEST,  4'd0,  -16'sd30000,    16'sd30000,    5'd0, 1'b0, 1'b0},
         '{ROW_TEST,  4'd0,  16'sd30000,     -16'sd30000,   5'd0, 1'b0, 1'b0},
         '{ROW_TEST,  4'd0,  16'sd0,         16'sd0,        5'd0, 1'b0, 1'b0},
         '{ROW_WRITE, 4'd15, -16'sd1,        -16'sd1,       5'd0, 1'b0, 1'b0},
         '{ROW_COUNT, 4'd0,  16'sd0,         16'sd0,        5'd3, 1'b0, 1'b0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_COUNT) begin
            write_count(row.count);
         end else begin
            send_word((row.kind == ROW_WRITE) ? pip_pkg::MODE_WRITE : pip_pkg::MODE_TEST,
                      row.index, row.x, row.y, row.typed, row.answer);
         end
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 4)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct   = 83;
               stall_pct = 0;
            end
            2: begin
               gap_pct   = 0;
               stall_pct = 83;
            end
            default: begin
               gap_pct   = 29;
               stall_pct = 29;
            end
         endcase
         case (ph)
            0: next_count = 31;
            1: next_count = pip_pkg::MAX_VERTICES;
            2: next_count = pip_pkg::MIN_VERTICES;
            3: next_count = 0;
            default: next_count = $urandom_range(31);
         endcase
         write_count(pip_pkg::COUNT_BITS'(next_count));
         // Fill every slot once so that no test word reads an unwritten vertex.
         if (ph == 0) send_polygon(pip_pkg::MAX_VERTICES, SHAPE_WIDE);
         start  = words_sent;
         paused = 1'b0;
         while (words_sent - start < WORDS_PER_PHASE) begin
            shape = shape_type'($urandom_range(2));
            if ($urandom_range(9) < 7) begin
               send_polygon(active_corners(), shape);
               send_queries(active_corners(), shape, $urandom_range(2, 8));
            end else begin
               repeat ($urandom_range(1, 4))
                  send_word(logic'($urandom_range(1)), pip_pkg::IDX_BITS'($urandom),
                            pick_coord(SHAPE_WIDE), pick_coord(SHAPE_WIDE), 1'b0, 1'b0);
            end
            if (!paused) begin
               drain_results(0);
               paused = 1'b1;
            end
         end
      end

      drain_results(SETTLE_CYCLES);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
